// ===== hw/rtl/serial_load_frame_parser_unit_macros.svh =====
// assertion macros for the serial load frame parser
`ifndef SERIAL_LOAD_FRAME_PARSER_UNIT_MACROS_SVH
`define SERIAL_LOAD_FRAME_PARSER_UNIT_MACROS_SVH

// checked only outside reset
`define SLFP_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// checked in and out of reset
`define SLFP_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ===== hw/rtl/slfp_pkg.sv =====
// shared types and constants of the serial load frame parser
package slfp_pkg;

  localparam logic [31:0] HEADER_RESET = 32'hCAFECAFE;
  localparam logic [31:0] WORD_BYTES   = 32'd4;

  localparam logic EV_WRITE = 1'b0;
  localparam logic EV_BOOT  = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_ADDR = 2'd1,
    PH_SIZE = 2'd2,
    PH_DATA = 2'd3
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] address;
    logic [31:0] data;
    logic        last;
  } evt_t;

  typedef struct packed {
    logic [1:0] count;
    evt_t       ev0;
    evt_t       ev1;
  } push_t;

endpackage

// ===== hw/rtl/slfp_if.sv =====
// byte and event channel interfaces
interface slfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface slfp_event_if;
  logic        valid;
  logic        ready;
  logic        event_kind;
  logic [31:0] address;
  logic [31:0] data;
  logic        last;

  modport source (output valid, output event_kind, output address, output data,
                  output last, input ready);
  modport sink (input valid, input event_kind, input address, input data,
                input last, output ready);
endinterface

// ===== hw/rtl/slfp_core.sv =====
// byte packing, frame phase tracking and event generation
module slfp_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [31:0]          cfg_wr_data,
  input  logic                 accept,
  input  logic [7:0]           rx_byte,
  output slfp_pkg::push_t      push
);
  import slfp_pkg::*;

  logic [31:0] header_value;
  logic [1:0]  byte_position, byte_position_next;
  logic [23:0] partial_word, partial_word_next;
  phase_t      phase, phase_next;
  logic [31:0] write_address, write_address_next;
  logic [31:0] start_address, start_address_next;
  logic [29:0] words_remaining, words_remaining_next;

  logic [31:0] word;
  logic [29:0] count_dec;
  evt_t        boot_ev;
  evt_t        write_ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_value    <= HEADER_RESET;
      byte_position   <= '0;
      partial_word    <= '0;
      phase           <= PH_HUNT;
      write_address   <= '0;
      start_address   <= '0;
      words_remaining <= '0;
    end else begin
      if (cfg_wr_en) begin
        header_value <= cfg_wr_data;
      end
      byte_position   <= byte_position_next;
      partial_word    <= partial_word_next;
      phase           <= phase_next;
      write_address   <= write_address_next;
      start_address   <= start_address_next;
      words_remaining <= words_remaining_next;
    end
  end

  always_comb begin
    byte_position_next   = byte_position;
    partial_word_next    = partial_word;
    phase_next           = phase;
    write_address_next   = write_address;
    start_address_next   = start_address;
    words_remaining_next = words_remaining;
    word      = {rx_byte, partial_word};
    count_dec = words_remaining - 30'd1;
    boot_ev   = '{kind: EV_BOOT, address: start_address, data: 32'd0, last: 1'b1};
    write_ev  = '{kind: EV_WRITE, address: write_address, data: word, last: 1'b0};
    push      = '0;
    if (accept) begin
      if (byte_position != 2'd3) begin
        case (byte_position)
          2'd0:    partial_word_next[7:0]   = rx_byte;
          2'd1:    partial_word_next[15:8]  = rx_byte;
          default: partial_word_next[23:16] = rx_byte;
        endcase
        byte_position_next = byte_position + 2'd1;
      end else begin
        partial_word_next  = '0;
        byte_position_next = '0;
        case (phase)
          PH_HUNT: begin
            if (word == header_value) begin
              phase_next = PH_ADDR;
            end
          end
          PH_ADDR: begin
            start_address_next = word;
            write_address_next = word;
            phase_next         = PH_SIZE;
          end
          PH_SIZE: begin
            words_remaining_next = word[31:2];
            if (word[31:2] == 30'd0) begin
              phase_next = PH_HUNT;
              push.count = 2'd1;
              push.ev0   = boot_ev;
            end else begin
              phase_next = PH_DATA;
            end
          end
          default: begin
            write_address_next   = write_address + WORD_BYTES;
            words_remaining_next = count_dec;
            push.ev0             = write_ev;
            if (count_dec == 30'd0) begin
              phase_next = PH_HUNT;
              push.count = 2'd2;
              push.ev1   = boot_ev;
            end else begin
              push.count    = 2'd1;
              push.ev0.last = 1'b1;
            end
          end
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/slfp_out_queue.sv =====
// four-entry event queue, up to two pushes and one pop per cycle
module slfp_out_queue (
  input  logic            clk,
  input  logic            rst,
  input  slfp_pkg::push_t push,
  output logic            room,
  input  logic            pop,
  output logic            head_valid,
  output slfp_pkg::evt_t  head
);
  import slfp_pkg::*;

  evt_t       entries [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count, count_next;

  assign room       = (count <= 3'd2);
  assign head_valid = (count != 3'd0);
  assign head       = entries[rd_ptr];

  always_comb begin
    count_next = count + {1'b0, push.count} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.ev0;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + 2'd1] <= push.ev1;
    end
  end

endmodule

// ===== hw/rtl/serial_load_frame_parser_unit.sv =====
// serial load frame parser top level
// an event is written into the event queue register when the byte that completes its word is accepted
// throughput: one byte per cycle; at most two events per word, one event per cycle out
// the byte side stalls only when the four-entry event queue cannot take two more
// reset clears the queue, the byte packer and the frame phase; header reloads 0xcafecafe
module serial_load_frame_parser_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,
  slfp_byte_if.sink    rx,
  slfp_event_if.source ev
);
  import slfp_pkg::*;

  logic  accept;
  logic  room;
  logic  head_valid;
  logic  pop;
  push_t push;
  evt_t  head;

  assign rx.ready = room;
  assign accept   = rx.valid && rx.ready;
  assign pop      = ev.valid && ev.ready;

  slfp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .rx_byte     (rx.rx_byte),
    .push        (push)
  );

  slfp_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  assign ev.valid      = head_valid;
  assign ev.event_kind = head.kind;
  assign ev.address    = head.address;
  assign ev.data       = head.data;
  assign ev.last       = head.last;

endmodule

// ===== hw/rtl/slfp_checker.sv =====
// port-level checks of the serial load frame parser
`include "serial_load_frame_parser_unit_macros.svh"

module slfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [31:0] out_address,
  input logic [31:0] out_data,
  input logic        out_last
);
  import slfp_pkg::*;

  `SLFP_ASSERT_ALWAYS(a_empty_after_reset, clk, rst |=> !out_valid, "event after reset")
  `SLFP_ASSERT(a_boot_shape, clk, rst,
    (out_valid && out_kind == EV_BOOT) |-> (out_data == 32'd0 && out_last),
    "bad boot beat")
  `SLFP_ASSERT(a_write_then_boot, clk, rst,
    (out_valid && out_ready && out_kind == EV_WRITE && !out_last)
      |=> (out_valid && out_kind == EV_BOOT),
    "write without last not followed by boot")
  `SLFP_ASSERT(a_stall_hold, clk, rst,
    (out_valid && !out_ready)
      |=> (out_valid && $stable(out_address) && $stable(out_data) && $stable(out_kind)),
    "stalled beat changed")

endmodule

bind serial_load_frame_parser_unit slfp_checker u_slfp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (ev.valid),
  .out_ready   (ev.ready),
  .out_kind    (ev.event_kind),
  .out_address (ev.address),
  .out_data    (ev.data),
  .out_last    (ev.last)
);
